// ===== src/cst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

	localparam int NUM_SEMS = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int SLOT_W = $clog2(NUM_SEMS);

	localparam int ACTION_W = 2;
	localparam int ID_W = 8;
	localparam int INIT_W = 16;
	localparam int STATUS_W = 2;
	localparam int HANDLE_W = 5;
	localparam int NREL_W = 16;

	// Wide enough to hold the negation of the most negative count.
	localparam int WIDE_W = 33;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CREATE,
		ACT_DESTROY,
		ACT_WAIT,
		ACT_SIGNAL
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_BAD,
		ST_FULL,
		ST_OVF
	} status_t;

	typedef logic signed [COUNT_WIDTH-1:0] count_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam count_t CNT_MAX = count_t'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);
	localparam count_t CNT_MIN = count_t'(64'd1 << (COUNT_WIDTH - 1));
	localparam wide_t CNT_MAX_X = wide_t'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);
	localparam wide_t NREL_MAX_X = wide_t'((64'd1 << NREL_W) - 64'd1);
	localparam logic [ID_W:0] NUM_SEMS_X = (ID_W + 1)'(NUM_SEMS);

	typedef struct packed {
		logic found;
		logic [SLOT_W-1:0] slot;
	} free_slot_t;

endpackage

`default_nettype wire

// ===== src/cst_free_slot.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cst_free_slot (
	input  wire logic [cst_pkg::NUM_SEMS-1:0] in_use,
	output cst_pkg::free_slot_t               free
);

	// The lowest free slot wins.
	always_comb begin
		free.found = 1'b0;
		free.slot = '0;
		for (int i = cst_pkg::NUM_SEMS - 1; i >= 0; i--) begin
			if (!in_use[i]) begin
				free.found = 1'b1;
				free.slot = cst_pkg::SLOT_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/counting_semaphore_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Table of 32 counting semaphores with 16-bit signed counts. A request
// (create, destroy, wait or signal) is taken whenever start is high; busy
// stays low, so one request can enter every clock cycle. Each request gives
// exactly one result beat after it is taken: it is held in the input register,
// then one read-modify-write of the table fills the result register. The
// result is shown for a single cycle with done high and cannot be held off,
// so the receiver must take it in that cycle. A request sees every table
// update made by the requests before it. Reset frees every slot.
module counting_semaphore_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [cst_pkg::ACTION_W-1:0]   action,
	input  wire logic [cst_pkg::ID_W-1:0]       sem_id,
	input  wire logic signed [cst_pkg::INIT_W-1:0] initial_count,
	output logic                                done,
	output logic [cst_pkg::STATUS_W-1:0]        status,
	output logic [cst_pkg::HANDLE_W-1:0]        handle,
	output logic                                block_caller,
	output logic                                wake_one,
	output logic                                release_all,
	output logic [cst_pkg::NREL_W-1:0]          released_waiters
);

	logic                                 valid_s1;
	cst_pkg::action_t                     action_s1;
	logic [cst_pkg::ID_W-1:0]             id_s1;
	logic signed [cst_pkg::INIT_W-1:0]    init_s1;

	logic [cst_pkg::NUM_SEMS-1:0]         in_use_q;
	cst_pkg::count_t                      count_q [cst_pkg::NUM_SEMS];

	cst_pkg::free_slot_t                  free;
	logic [cst_pkg::SLOT_W-1:0]           id_idx;
	logic                                 id_ok;
	cst_pkg::count_t                      cur;
	cst_pkg::count_t                      dec;
	cst_pkg::count_t                      inc;
	cst_pkg::wide_t                       cur_x;
	cst_pkg::wide_t                       neg_x;
	cst_pkg::wide_t                       init_x;

	cst_pkg::status_t                     st_d;
	logic [cst_pkg::HANDLE_W-1:0]         hnd_d;
	logic                                 blk_d;
	logic                                 wake_d;
	logic                                 rel_d;
	logic [cst_pkg::NREL_W-1:0]           nrel_d;
	logic                                 wr_en;
	logic [cst_pkg::SLOT_W-1:0]           wr_idx;
	cst_pkg::count_t                      wr_cnt;
	logic                                 set_use;
	logic                                 clr_use;

	logic                                 done_q;
	cst_pkg::status_t                     status_q;
	logic [cst_pkg::HANDLE_W-1:0]         handle_q;
	logic                                 block_q;
	logic                                 wake_q;
	logic                                 release_q;
	logic [cst_pkg::NREL_W-1:0]           nrel_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1 <= cst_pkg::action_t'(action);
			id_s1 <= sem_id;
			init_s1 <= initial_count;
		end
	end

	cst_free_slot u_free_slot (
		.in_use (in_use_q),
		.free   (free)
	);

	assign id_idx = id_s1[cst_pkg::SLOT_W-1:0];
	assign id_ok = {1'b0, id_s1} < cst_pkg::NUM_SEMS_X;
	assign cur = count_q[id_idx];
	assign dec = cur - cst_pkg::count_t'(1);
	assign inc = cur + cst_pkg::count_t'(1);
	assign cur_x = cst_pkg::wide_t'(cur);
	assign neg_x = -cur_x;
	assign init_x = cst_pkg::wide_t'(init_s1);

	always_comb begin
		st_d = cst_pkg::ST_OK;
		hnd_d = '0;
		blk_d = 1'b0;
		wake_d = 1'b0;
		rel_d = 1'b0;
		nrel_d = '0;
		wr_en = 1'b0;
		wr_idx = id_idx;
		wr_cnt = cur;
		set_use = 1'b0;
		clr_use = 1'b0;
		if (action_s1 == cst_pkg::ACT_CREATE) begin
			priority if (init_x < 0) begin
				st_d = cst_pkg::ST_BAD;
			end else if (init_x > cst_pkg::CNT_MAX_X) begin
				st_d = cst_pkg::ST_OVF;
			end else if (!free.found) begin
				st_d = cst_pkg::ST_FULL;
			end else begin
				wr_en = 1'b1;
				wr_idx = free.slot;
				wr_cnt = cst_pkg::count_t'(init_s1);
				set_use = 1'b1;
				hnd_d = cst_pkg::HANDLE_W'(free.slot);
			end
		end else if (!id_ok || !in_use_q[id_idx]) begin
			st_d = cst_pkg::ST_BAD;
		end else begin
			unique case (action_s1)
				cst_pkg::ACT_DESTROY: begin
					wr_en = 1'b1;
					wr_cnt = '0;
					clr_use = 1'b1;
					rel_d = 1'b1;
					if (cur < 0) begin
						nrel_d = (neg_x > cst_pkg::NREL_MAX_X) ? '1 : neg_x[cst_pkg::NREL_W-1:0];
					end
				end
				cst_pkg::ACT_WAIT: begin
					if (cur == cst_pkg::CNT_MIN) begin
						st_d = cst_pkg::ST_OVF;
					end else begin
						wr_en = 1'b1;
						wr_cnt = dec;
						blk_d = dec < 0;
					end
				end
				default: begin
					if (cur == cst_pkg::CNT_MAX) begin
						st_d = cst_pkg::ST_OVF;
					end else begin
						wr_en = 1'b1;
						wr_cnt = inc;
						wake_d = inc <= 0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < cst_pkg::NUM_SEMS; i++) begin
				count_q[i] <= '0;
			end
		end else if (valid_s1) begin
			if (wr_en) begin
				count_q[wr_idx] <= wr_cnt;
			end
			if (set_use) begin
				in_use_q[wr_idx] <= 1'b1;
			end
			if (clr_use) begin
				in_use_q[wr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= st_d;
			handle_q <= hnd_d;
			block_q <= blk_d;
			wake_q <= wake_d;
			release_q <= rel_d;
			nrel_q <= nrel_d;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign handle = handle_q;
	assign block_caller = block_q;
	assign wake_one = wake_q;
	assign release_all = release_q;
	assign released_waiters = nrel_q;

`ifndef SYNTHESIS
	// A result beat always follows an accepted request, through the input and result registers.
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without a request two cycles earlier");

	// A successful create leaves its slot in use.
	a_create_marks_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && set_use) |=> in_use_q[$past(free.slot)])
		else $error("created slot not marked in use");

	// Block, wake and release indications only come with a good status.
	a_flags_need_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (block_caller || wake_one || release_all)) |->
		(status == cst_pkg::ST_OK))
		else $error("indication raised on a failed request");

	// Waiters are only reported by a destroy that freed a slot.
	a_waiters_need_release: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (released_waiters != '0)) |-> release_all)
		else $error("released waiters without release");
`endif

endmodule

`default_nettype wire
